// ===== sv/arithmetic_expression_tokenizer_assert.svh =====
// Assertion macros for the arithmetic expression tokenizer.
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_ASSERT_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while reset is low.
`define AET_ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define AET_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AET_ASSERT_RUN(label, clk, rst, prop, msg)
`define AET_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== sv/aet_pkg.sv =====
// Shared types, constants and helper functions of the arithmetic expression tokenizer.
`default_nettype none

package aet_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;

  localparam logic [3:0] KIND_INT     = 4'd0;
  localparam logic [3:0] KIND_PLUS    = 4'd1;
  localparam logic [3:0] KIND_MINUS   = 4'd2;
  localparam logic [3:0] KIND_STAR    = 4'd3;
  localparam logic [3:0] KIND_SLASH   = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_END     = 4'd7;
  localparam logic [3:0] KIND_ILLEGAL = 4'd8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_NUMBER  = 3'b010,
    MODE_COMMENT = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic                   last_of_run;
  } out_item_t;

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] column_inc(input logic [COLUMN_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] offset_inc(input logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arithmetic_expression_tokenizer.sv =====
// A token is registered and offered on out_item in the cycle after the byte that completes it.
// Throughput: one byte per cycle while out_stall is low; a byte that both ends a digit run
// and forms a token of its own yields two tokens, and the input stalls while both are queued.
// The two-entry output queue sets that figure: a byte is taken only when the queue
// will be empty after this cycle's pop.
// Reset: line 1, column 0, offset 0, normal scan mode, output queue empty.
`default_nettype none

`include "arithmetic_expression_tokenizer_assert.svh"

module arithmetic_expression_tokenizer
  import aet_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  scan_mode_t             scan_mode, scan_mode_next;
  logic [LINE_BITS-1:0]   current_line, line_now;
  logic [COLUMN_BITS-1:0] current_column, column_now;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   previous_was_newline;
  logic [LINE_BITS-1:0]   number_start_line;
  logic [COLUMN_BITS-1:0] number_start_column;
  logic [OFFSET_BITS-1:0] number_start_offset;
  logic [OFFSET_BITS-1:0] number_length, number_length_next;

  out_item_t  slot0, slot1;
  logic [1:0] fill;

  logic       accept, pop;
  logic [7:0] ch;
  logic       is_digit, is_space, is_term, in_number, in_comment;
  logic       char_active, emit_int, emit_char, start_number;
  logic [3:0] char_kind;
  out_item_t  int_tok, char_tok, res0;
  logic [1:0] res_count;

  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((fill == 2'd0) || (fill == 2'd1 && pop));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (fill != 2'd0);
  assign out_item  = slot0;

  always_comb begin
    ch         = in_item.end_of_text ? CH_NUL : in_item.source_byte;
    is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_space   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
    is_term    = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL);
    in_number  = (scan_mode == MODE_NUMBER);
    in_comment = (scan_mode == MODE_COMMENT);

    line_now   = previous_was_newline ? line_inc(current_line) : current_line;
    column_now = previous_was_newline ? COLUMN_BITS'(1) : column_inc(current_column);

    // A digit inside a run, or any byte inside a comment but its terminator,
    // is absorbed without looking at it as a token start.
    char_active  = !(in_number && is_digit) && !(in_comment && !is_term);
    emit_int     = in_number && !is_digit;
    emit_char    = char_active && !is_space && (ch != CH_HASH) && !is_digit;
    start_number = char_active && is_digit;

    if (in_number && is_digit) begin
      scan_mode_next = MODE_NUMBER;
    end else if (in_comment && !is_term) begin
      scan_mode_next = MODE_COMMENT;
    end else if (ch == CH_HASH) begin
      scan_mode_next = MODE_COMMENT;
    end else if (is_digit) begin
      scan_mode_next = MODE_NUMBER;
    end else begin
      scan_mode_next = MODE_NORMAL;
    end

    if (in_number && is_digit) begin
      number_length_next = offset_inc(number_length);
    end else if (start_number) begin
      number_length_next = OFFSET_BITS'(1);
    end else begin
      number_length_next = number_length;
    end

    case (ch)
      CH_NUL:    char_kind = KIND_END;
      CH_PLUS:   char_kind = KIND_PLUS;
      CH_MINUS:  char_kind = KIND_MINUS;
      CH_STAR:   char_kind = KIND_STAR;
      CH_SLASH:  char_kind = KIND_SLASH;
      CH_LPAREN: char_kind = KIND_LPAREN;
      CH_RPAREN: char_kind = KIND_RPAREN;
      default:   char_kind = KIND_ILLEGAL;
    endcase

    char_tok.token_kind   = char_kind;
    char_tok.start_line   = line_now;
    char_tok.start_column = column_now;
    char_tok.start_offset = byte_offset;
    char_tok.token_length = OFFSET_BITS'(1);
    char_tok.last_of_run  = 1'b1;

    int_tok.token_kind   = KIND_INT;
    int_tok.start_line   = number_start_line;
    int_tok.start_column = number_start_column;
    int_tok.start_offset = number_start_offset;
    int_tok.token_length = number_length;
    int_tok.last_of_run  = !emit_char;

    res0      = emit_int ? int_tok : char_tok;
    res_count = {1'b0, emit_int} + {1'b0, emit_char};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode            <= MODE_NORMAL;
      current_line         <= LINE_BITS'(1);
      current_column       <= '0;
      byte_offset          <= '0;
      previous_was_newline <= 1'b0;
      number_start_line    <= '0;
      number_start_column  <= '0;
      number_start_offset  <= '0;
      number_length        <= '0;
      fill                 <= 2'd0;
    end else begin
      if (accept) begin
        scan_mode            <= scan_mode_next;
        current_line         <= line_now;
        current_column       <= column_now;
        byte_offset          <= offset_inc(byte_offset);
        previous_was_newline <= (ch == CH_LF);
        number_length        <= number_length_next;
        if (start_number) begin
          number_start_line   <= line_now;
          number_start_column <= column_now;
          number_start_offset <= byte_offset;
        end
        // The queue is empty after this cycle's pop whenever a byte is taken.
        fill <= res_count;
      end else if (pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= res0;
      slot1 <= char_tok;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  `AET_ASSERT_ALWAYS(a_line_nonzero, clk, rst || current_line != '0,
                     "line counter reached zero")
  `AET_ASSERT_RUN(a_partner_queued, clk, rst,
                  out_valid && !out_item.last_of_run |-> fill == 2'd2,
                  "non-final token without a queued partner")
  `AET_ASSERT_RUN(a_end_token, clk, rst,
                  accept && in_item.end_of_text |=>
                    (fill == 2'd1 && slot0.token_kind == KIND_END) ||
                    (fill == 2'd2 && slot1.token_kind == KIND_END),
                  "end marker did not queue an end token")
  `AET_ASSERT_RUN(a_fill_range, clk, rst, fill != 2'd3,
                  "output queue overfilled")

endmodule

`default_nettype wire
